@@ rtl/core/pbr_pkg.sv @@
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and constants of the partitioned buffer replacement unit.
// ----------------------------------------------------------------------------
package pbr_pkg;

   localparam int SLOTS   = 256;
   localparam int SLOT_IW = $clog2(SLOTS);
   localparam int SLOT_CW = SLOT_IW + 1;
   localparam int TENANTS = 16;
   localparam int TEN_W   = 4;
   localparam int PAGE_W  = 10;
   localparam int QUOTA_W = 9;
   localparam int FREQ_W  = 16;
   localparam int FREQ_AW = TEN_W + PAGE_W;
   localparam int STAMP_W = 32;

   localparam logic REQ_QUOTA  = 1'b0;
   localparam logic REQ_ACCESS = 1'b1;

   localparam logic CSR_NUM_TENANTS = 1'b0;
   localparam logic CSR_NUM_SLOTS   = 1'b1;

   localparam logic [2:0] STATUS_HIT   = 3'd0;
   localparam logic [2:0] STATUS_FREE  = 3'd1;
   localparam logic [2:0] STATUS_OWN   = 3'd2;
   localparam logic [2:0] STATUS_OTHER = 3'd3;
   localparam logic [2:0] STATUS_NOVIC = 3'd4;

   typedef struct packed {
      logic               req_type;
      logic [TEN_W-1:0]   tenant;
      logic [PAGE_W-1:0]  page;
      logic [QUOTA_W-1:0] min_quota;
      logic [QUOTA_W-1:0] max_quota;
   } req_beat_type;

   typedef struct packed {
      logic [8:0]        slot;
      logic [2:0]        status;
      logic [TEN_W-1:0]  evicted_tenant;
      logic [PAGE_W-1:0] evicted_page;
      logic              lfu_used;
   } rsp_beat_type;

   typedef struct packed {
      logic [TEN_W-1:0]   tenant;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] last_use;
   } slot_entry_type;

   typedef struct packed {
      logic               clr;
      logic               vld;
      logic [SLOT_IW-1:0] idx;
      logic               occupied;
      logic [TEN_W-1:0]   tenant;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] weight;
   } scan_in_type;

   typedef struct packed {
      logic               hit_found;
      logic [SLOT_IW-1:0] hit_idx;
      logic               free_found;
      logic [SLOT_IW-1:0] free_idx;
      logic               own_found;
      logic [SLOT_IW-1:0] own_idx;
      logic [PAGE_W-1:0]  own_page;
      logic               glob_found;
      logic [SLOT_IW-1:0] glob_idx;
      logic [TEN_W-1:0]   glob_tenant;
      logic [PAGE_W-1:0]  glob_page;
   } scan_res_type;

endpackage

@@ rtl/core/pbr_ram.sv @@
// ----------------------------------------------------------------------------
// pbr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbr_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pbr_scan.sv @@
// ----------------------------------------------------------------------------
// pbr_scan
// Running trackers over the slot scan: hit, lowest free slot, own least-weight
// page and least-weight page among tenants above their minimum.
// ----------------------------------------------------------------------------
module pbr_scan
   import pbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  scan_in_type         scan,
   input  logic [TEN_W-1:0]    req_tenant,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic [SLOT_CW-1:0]  slot_limit,
   input  logic [TENANTS-1:0]  elig,
   output scan_res_type        res
);

   scan_res_type       res_ff;
   logic [STAMP_W-1:0] own_w_ff;
   logic [STAMP_W-1:0] glob_w_ff;
   logic               is_hit;
   logic               is_free;
   logic               own_better;
   logic               glob_better;

   always_comb begin
      is_hit  = scan.occupied && scan.tenant == req_tenant && scan.page == req_page;
      is_free = !scan.occupied && ({1'b0, scan.idx} < slot_limit);
      own_better = scan.occupied && scan.tenant == req_tenant &&
                   (!res_ff.own_found || scan.weight < own_w_ff ||
                    (scan.weight == own_w_ff && scan.page < res_ff.own_page));
      glob_better = scan.occupied && elig[scan.tenant] &&
                    (!res_ff.glob_found || scan.weight < glob_w_ff ||
                     (scan.weight == glob_w_ff &&
                      (scan.tenant < res_ff.glob_tenant ||
                       (scan.tenant == res_ff.glob_tenant &&
                        scan.page < res_ff.glob_page))));
   end

   always_ff @(posedge clock) begin
      if (reset || scan.clr) begin
         res_ff.hit_found  <= 1'b0;
         res_ff.free_found <= 1'b0;
         res_ff.own_found  <= 1'b0;
         res_ff.glob_found <= 1'b0;
      end else if (scan.vld) begin
         if (!res_ff.hit_found && is_hit) begin
            res_ff.hit_found <= 1'b1;
            res_ff.hit_idx   <= scan.idx;
         end
         if (!res_ff.free_found && is_free) begin
            res_ff.free_found <= 1'b1;
            res_ff.free_idx   <= scan.idx;
         end
         if (own_better) begin
            res_ff.own_found <= 1'b1;
            res_ff.own_idx   <= scan.idx;
            res_ff.own_page  <= scan.page;
            own_w_ff         <= scan.weight;
         end
         if (glob_better) begin
            res_ff.glob_found  <= 1'b1;
            res_ff.glob_idx    <= scan.idx;
            res_ff.glob_tenant <= scan.tenant;
            res_ff.glob_page   <= scan.page;
            glob_w_ff          <= scan.weight;
         end
      end
   end

   assign res = res_ff;

endmodule

@@ rtl/core/partitioned_buffer_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// partitioned_buffer_replacement_unit
// Slot allocator for a tenant-partitioned buffer with adaptive LFU/LRU
// replacement, built around a slot memory and a page frequency memory.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  req_beat_type
//   rsp_     out        rsp_valid/rsp_stall  rsp_beat_type
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Quota load beat: taken in S_IDLE, no response.
// Access beat: a scan of the slot memory, one slot per cycle,
// followed by the read-modify-write of the frequency memory.
// After reset, a pass over all 2**FREQ_AW entries clears the frequency memory;
// req_stall stays high meanwhile, CSR writes are taken throughout.
// The next beat is taken while a response waits on a stalled rsp_ channel.
// ----------------------------------------------------------------------------
module partitioned_buffer_replacement_unit
   import pbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_beat_type        req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_beat_type        rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [QUOTA_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PREP, S_SCAN, S_DRAIN1, S_DRAIN2,
      S_DECIDE, S_UPDATE, S_INC, S_POLICY, S_OUT
   } state_type;

   state_type           state_ff;
   logic [FREQ_AW-1:0]  clr_ff;
   logic [SLOT_IW-1:0]  sc_ff;
   logic [TEN_W-1:0]    t_ff;
   logic [PAGE_W-1:0]   p_ff;
   logic [STAMP_W-1:0]  ac_ff;
   logic [STAMP_W-1:0]  ws_ff;
   logic [STAMP_W-1:0]  ec_ff;
   logic                lfu_ff;
   logic                pol_ff;
   logic                full_ff;
   logic [TENANTS-1:0]  elig_ff;
   logic [TENANTS-1:0]  elig_in;
   logic [SLOTS-1:0]    occ_ff;
   logic [4:0]          num_tenants_ff;
   logic [QUOTA_W-1:0]  num_slots_ff;
   logic [QUOTA_W-1:0]  used_ff [TENANTS];
   logic [QUOTA_W-1:0]  minq_ff [TENANTS];
   logic [QUOTA_W-1:0]  maxq_ff [TENANTS];

   logic                s1_vld_ff;
   logic [SLOT_IW-1:0]  s1_idx_ff;
   logic                s1_occ_ff;
   logic                s2_vld_ff;
   logic [SLOT_IW-1:0]  s2_idx_ff;
   logic                s2_occ_ff;
   slot_entry_type      s2_ent_ff;

   logic [2:0]          status_ff;
   logic [SLOT_IW-1:0]  vic_ff;
   logic [TEN_W-1:0]    evt_ff;
   logic [PAGE_W-1:0]   evp_ff;

   logic                rsp_valid_ff;
   rsp_beat_type        rsp_ff;

   slot_entry_type      slot_rd;
   logic [$bits(slot_entry_type)-1:0] slot_rd_bits;
   logic [FREQ_W-1:0]   freq_rd;
   logic                freq_we;
   logic [FREQ_AW-1:0]  freq_wa;
   logic [FREQ_W-1:0]   freq_wd;
   logic [FREQ_AW-1:0]  freq_ra;
   logic [SLOT_CW-1:0]  slot_limit;
   scan_in_type         scan;
   scan_res_type        res;
   logic                req_acc;
   logic                rsp_free;
   logic [STAMP_W-1:0]  window;
   logic [STAMP_W+2:0]  five_ec;
   logic [STAMP_W+2:0]  three_win;
   logic                flip;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign slot_limit = (num_slots_ff > QUOTA_W'(SLOTS)) ? SLOT_CW'(SLOTS)
                                                         : SLOT_CW'(num_slots_ff);

   always_comb begin
      for (int i = 0; i < TENANTS; i++) begin
         elig_in[i] = (5'(i) < num_tenants_ff) && (minq_ff[i] < used_ff[i]);
      end
   end

   // memories
   pbr_ram #(.DEPTH(SLOTS), .WIDTH($bits(slot_entry_type))) u_slot_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_UPDATE),
      .wr_addr (vic_ff),
      .wr_data ({t_ff, p_ff, ac_ff}),
      .rd_addr (sc_ff),
      .rd_data (slot_rd_bits)
   );
   assign slot_rd = slot_entry_type'(slot_rd_bits);

   always_comb begin
      freq_we = 1'b0;
      freq_wa = {t_ff, p_ff};
      freq_wd = (freq_rd == '1) ? freq_rd : freq_rd + FREQ_W'(1);
      if (state_ff == S_CLEAR) begin
         freq_we = 1'b1;
         freq_wa = clr_ff;
         freq_wd = '0;
      end else if (state_ff == S_INC) begin
         freq_we = 1'b1;
      end
      freq_ra = (state_ff == S_UPDATE) ? {t_ff, p_ff} : {slot_rd.tenant, slot_rd.page};
   end

   pbr_ram #(.DEPTH(2 ** FREQ_AW), .WIDTH(FREQ_W)) u_freq_ram (
      .clock   (clock),
      .wr_en   (freq_we),
      .wr_addr (freq_wa),
      .wr_data (freq_wd),
      .rd_addr (freq_ra),
      .rd_data (freq_rd)
   );

   always_comb begin
      scan.clr      = (state_ff == S_PREP);
      scan.vld      = s2_vld_ff;
      scan.idx      = s2_idx_ff;
      scan.occupied = s2_occ_ff;
      scan.tenant   = s2_ent_ff.tenant;
      scan.page     = s2_ent_ff.page;
      scan.weight   = pol_ff ? {{(STAMP_W-FREQ_W){1'b0}}, freq_rd} : s2_ent_ff.last_use;
   end

   pbr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan       (scan),
      .req_tenant (t_ff),
      .req_page   (p_ff),
      .slot_limit (slot_limit),
      .elig       (elig_ff),
      .res        (res)
   );

   // policy window, integer form of the 0.2 and 0.6 ratios
   always_comb begin
      window    = ac_ff - ws_ff;
      five_ec   = {3'b000, ec_ff} + {1'b0, ec_ff, 2'b00};
      three_win = {3'b000, window} + {2'b00, window, 1'b0};
      flip      = lfu_ff ? (five_ec > {3'b000, window}) : (five_ec > three_win);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         sc_ff          <= '0;
         ac_ff          <= '0;
         ws_ff          <= '0;
         ec_ff          <= '0;
         lfu_ff         <= 1'b1;
         occ_ff         <= '0;
         num_tenants_ff <= 5'd1;
         num_slots_ff   <= QUOTA_W'(256);
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < TENANTS; i++) begin
            used_ff[i] <= '0;
            minq_ff[i] <= '0;
            maxq_ff[i] <= '0;
         end
      end else begin
         if (state_ff == S_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_TENANTS) begin
               num_tenants_ff <= csr_wdata[4:0];
            end else begin
               num_slots_ff <= csr_wdata;
            end
         end

         s1_vld_ff <= (state_ff == S_SCAN);
         s1_idx_ff <= sc_ff;
         s1_occ_ff <= occ_ff[sc_ff];
         s2_vld_ff <= s1_vld_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_occ_ff <= s1_occ_ff;
         s2_ent_ff <= slot_rd;

         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + FREQ_AW'(1);
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  t_ff <= req_payload.tenant;
                  p_ff <= req_payload.page;
                  if (req_payload.req_type == REQ_QUOTA) begin
                     minq_ff[req_payload.tenant] <= req_payload.min_quota;
                     maxq_ff[req_payload.tenant] <= req_payload.max_quota;
                  end else begin
                     ac_ff    <= ac_ff + STAMP_W'(1);
                     state_ff <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               pol_ff   <= lfu_ff;
               full_ff  <= used_ff[t_ff] >= maxq_ff[t_ff];
               elig_ff  <= elig_in;
               sc_ff    <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               sc_ff <= sc_ff + SLOT_IW'(1);
               if (sc_ff == SLOT_IW'(SLOTS - 1)) begin
                  state_ff <= S_DRAIN1;
               end
            end
            S_DRAIN1: state_ff <= S_DRAIN2;
            S_DRAIN2: state_ff <= S_DECIDE;
            S_DECIDE: begin
               evt_ff   <= '0;
               evp_ff   <= '0;
               vic_ff   <= res.hit_idx;
               state_ff <= S_UPDATE;
               if (res.hit_found) begin
                  status_ff <= STATUS_HIT;
               end else if (full_ff) begin
                  if (res.own_found) begin
                     status_ff <= STATUS_OWN;
                     vic_ff    <= res.own_idx;
                     evt_ff    <= t_ff;
                     evp_ff    <= res.own_page;
                  end else begin
                     status_ff <= STATUS_NOVIC;
                     state_ff  <= S_POLICY;
                  end
               end else if (res.free_found) begin
                  status_ff <= STATUS_FREE;
                  vic_ff    <= res.free_idx;
               end else if (res.glob_found) begin
                  status_ff <= STATUS_OTHER;
                  vic_ff    <= res.glob_idx;
                  evt_ff    <= res.glob_tenant;
                  evp_ff    <= res.glob_page;
               end else begin
                  status_ff <= STATUS_NOVIC;
                  state_ff  <= S_POLICY;
               end
            end
            S_UPDATE: begin
               if (status_ff == STATUS_OWN || status_ff == STATUS_OTHER) begin
                  ec_ff <= ec_ff + STAMP_W'(1);
                  if (used_ff[evt_ff] != '0) begin
                     used_ff[evt_ff] <= used_ff[evt_ff] - QUOTA_W'(1);
                  end
               end
               occ_ff[vic_ff] <= 1'b1;
               state_ff       <= S_INC;
            end
            S_INC: begin
               if (status_ff != STATUS_HIT) begin
                  used_ff[t_ff] <= used_ff[t_ff] + QUOTA_W'(1);
               end
               state_ff <= S_POLICY;
            end
            S_POLICY: begin
               if (flip) begin
                  lfu_ff <= !lfu_ff;
                  ec_ff  <= '0;
                  ws_ff  <= ac_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_ff.slot           <= (status_ff == STATUS_NOVIC) ? 9'd0
                                           : 9'({1'b0, vic_ff}) + 9'd1;
                  rsp_ff.status         <= status_ff;
                  rsp_ff.evicted_tenant <= evt_ff;
                  rsp_ff.evicted_page   <= evp_ff;
                  rsp_ff.lfu_used       <= pol_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("beat taken during frequency clear");

   a_slot_given: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_NOVIC |-> rsp_payload.slot != 9'd0)
      else $error("slot missing on served access");

   a_no_evict_info: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_HIT || rsp_payload.status == STATUS_FREE ||
                    rsp_payload.status == STATUS_NOVIC)
      |-> rsp_payload.evicted_tenant == '0 && rsp_payload.evicted_page == '0)
      else $error("eviction fields set without eviction");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PREP |=> state_ff == S_SCAN && sc_ff == '0)
      else $error("scan did not start at slot zero");
`endif

endmodule
